// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the date to epoch seconds unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed: property does not hold");
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("assertion failed: forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ===== rtl/dtes_pkg.sv =====
// Package with types, phase codes and calendar tables of the date to epoch seconds unit.
package dtes_pkg;

    localparam int PHASE_W = 4;

    // Parse phase codes: one per expected character, plus the tail phase
    localparam logic [PHASE_W-1:0] PH_MON_T = 4'd0;
    localparam logic [PHASE_W-1:0] PH_MON_U = 4'd1;
    localparam logic [PHASE_W-1:0] PH_DAY_T = 4'd2;
    localparam logic [PHASE_W-1:0] PH_DAY_U = 4'd3;
    localparam logic [PHASE_W-1:0] PH_HR_T  = 4'd4;
    localparam logic [PHASE_W-1:0] PH_HR_U  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_MIN_T = 4'd6;
    localparam logic [PHASE_W-1:0] PH_MIN_U = 4'd7;
    localparam logic [PHASE_W-1:0] PH_YR_T  = 4'd8;
    localparam logic [PHASE_W-1:0] PH_YR_U  = 4'd9;
    localparam logic [PHASE_W-1:0] PH_PM    = 4'd10;
    localparam logic [PHASE_W-1:0] PH_TAIL  = 4'd11;

    // Character codes
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_PM   = 8'h70;

    localparam int DAYS_W = 17;
    localparam logic [7:0]  DEFAULT_YEAR_RST = 8'd70;
    localparam logic [31:0] SECS_PER_DAY     = 32'd86400;
    localparam logic [31:0] SECS_PER_HOUR    = 32'd3600;
    localparam logic [31:0] SECS_PER_MIN     = 32'd60;

    // Parsed date fields handed from the parser to the time calculation
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [3:0]         month;
        logic [5:0]         day;
        logic [5:0]         hour;
        logic [5:0]         minute;
        logic [7:0]         year;
        logic               year_given;
        logic               pm_seen;
        logic               error_seen;
    } date_fields_t;

    typedef logic [DAYS_W-1:0] year_days_t [256];

    // Days from 1970-01-01 to January 1st of each year from 1900 to 2155; zero up to 1970
    function automatic year_days_t build_year_days();
        year_days_t tbl;
        int         y;
        int         d;
        for (int i = 0; i < 256; i++) begin
            y = 1900 + i;
            d = 0;
            if (y > 1970) begin
                d = 365 * (y - 1970) + ((y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400)
                    - (1969 / 4 - 1969 / 100 + 1969 / 400);
            end
            tbl[i] = DAYS_W'(d);
        end
        return tbl;
    endfunction

    localparam year_days_t YEAR_DAYS = build_year_days();

    // Days in the year before the first of each month (months 1 to 12)
    function automatic logic [8:0] days_before_month(input logic [3:0] month);
        logic [8:0] d;
        case (month)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/date_digits_to_epoch_seconds_unit.sv =====
// Top level of the date to epoch seconds unit: input register, parser, result register.
//
//  channel | dir | payload                                  | transaction
//  --------+-----+------------------------------------------+---------------------------
//  s_      | in  | tdata[7:0] char_code                     | one string character
//  m_      | out | tdata[31:0] epoch_seconds, tuser bad_date| one result per NUL
//  cfg_    | in  | cfg_data[7:0] default_year               | register write
//
// One character per cycle sustained while each NUL finds room in the m_ register; a
// character is registered before the parser, and a NUL fills the m_ register as it leaves.
// The parse state register sets the rate: each character updates it in one step.
// Reset (aresetn low, synchronous) empties both registers, clears the parse state
// and sets default_year to 70. A stalled result holds only a NUL behind it;
// other characters keep flowing into the parser.
`include "assert_macros.svh"

module date_digits_to_epoch_seconds_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] epoch_seconds
    output logic        m_tuser,   // [0] bad_date
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data   // [7:0] default_year
);
    import dtes_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   in_char_reg;
    logic         m_valid_reg;
    logic [31:0]  m_data_reg;
    logic         m_bad_reg;
    logic [7:0]   default_year_reg;
    logic         out_free;
    logic         is_nul;
    logic         proc_go;
    date_fields_t fields;
    logic [31:0]  calc_seconds;
    logic         calc_bad;

    // Handshake: a NUL waits for room in the result register, others go at once
    assign out_free  = !m_valid_reg || m_tready;
    assign is_nul    = (in_char_reg == CH_NUL);
    assign proc_go   = in_valid_reg && (!is_nul || out_free);
    assign s_tready  = !in_valid_reg || proc_go;
    assign cfg_ready = 1'b1;

    // Hold the configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_year_reg <= DEFAULT_YEAR_RST;
        end else if (cfg_valid && cfg_ready) begin
            default_year_reg <= cfg_data;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
        end
    end

    dtes_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .char_go   (proc_go),
        .char_code (in_char_reg),
        .fields    (fields)
    );

    dtes_calc u_calc (
        .fields        (fields),
        .default_year  (default_year_reg),
        .epoch_seconds (calc_seconds),
        .bad_date      (calc_bad)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= proc_go && is_nul;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_go && is_nul) begin
            m_data_reg <= calc_seconds;
            m_bad_reg  <= calc_bad;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_bad_reg;

    // Parser returns to the month tens digit after every terminator
    `ASSERT_PROP(a_nul_clears, aclk, aresetn, (proc_go && is_nul) |=> (fields.phase == PH_MON_T))
    // A failed date always reports zero seconds
    `ASSERT_NEVER(a_bad_zero, aclk, aresetn, m_valid_reg && m_bad_reg && (m_data_reg != 32'd0))
    // A detected error parks the parser in the tail phase
    `ASSERT_PROP(a_err_tail, aclk, aresetn, fields.error_seen |-> (fields.phase == PH_TAIL))

endmodule

// ===== rtl/dtes_parse.sv =====
// Character parser: gathers the digit pairs of the date string and range-checks all but the year.
module dtes_parse (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  char_go,
    input  logic [7:0]            char_code,
    output dtes_pkg::date_fields_t fields
);
    import dtes_pkg::*;

    date_fields_t f_reg;
    date_fields_t f_next;
    logic [3:0]   tens_reg;
    logic [3:0]   tens_next;
    logic         is_digit;
    logic [3:0]   dv;
    logic [6:0]   pair;
    logic         pair_ok;

    assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign dv       = is_digit ? 4'(char_code - CH_ZERO) : 4'd0;
    assign pair     = 7'(tens_reg) * 7'd10 + 7'(dv);

    // Range check of the pair that completes in the current phase
    always_comb begin
        unique case (f_reg.phase)
            PH_MON_U: pair_ok = (pair >= 7'd1) && (pair <= 7'd12);
            PH_DAY_U: pair_ok = (pair >= 7'd1) && (pair <= 7'd31);
            PH_HR_U:  pair_ok = (pair <= 7'd24);
            default:  pair_ok = (pair <= 7'd59);
        endcase
    end

    // Advance the parse state on each character until the tail phase, clear it on the terminator
    always_comb begin
        f_next    = f_reg;
        tens_next = tens_reg;
        if (char_go) begin
            if (char_code == CH_NUL) begin
                f_next    = '0;
                tens_next = '0;
            end else begin
                unique case (f_reg.phase) inside
                    PH_MON_T, PH_DAY_T, PH_HR_T, PH_MIN_T: begin
                        if (is_digit) begin
                            tens_next    = dv;
                            f_next.phase = f_reg.phase + 1'b1;
                        end else begin
                            f_next.error_seen = 1'b1;
                            f_next.phase      = PH_TAIL;
                        end
                    end
                    PH_MON_U, PH_DAY_U, PH_HR_U, PH_MIN_U: begin
                        if (is_digit) begin
                            if (f_reg.phase == PH_MON_U) begin
                                f_next.month = pair[3:0];
                            end else if (f_reg.phase == PH_DAY_U) begin
                                f_next.day = pair[5:0];
                            end else if (f_reg.phase == PH_HR_U) begin
                                f_next.hour = pair[5:0];
                            end else begin
                                f_next.minute = pair[5:0];
                            end
                        end
                        if (is_digit && pair_ok) begin
                            f_next.phase = f_reg.phase + 1'b1;
                        end else begin
                            f_next.error_seen = 1'b1;
                            f_next.phase      = PH_TAIL;
                        end
                    end
                    PH_YR_T: begin
                        if (is_digit) begin
                            tens_next    = dv;
                            f_next.phase = PH_YR_U;
                        end else begin
                            if (char_code == CH_PM) begin
                                f_next.pm_seen = 1'b1;
                            end
                            f_next.phase = PH_TAIL;
                        end
                    end
                    PH_YR_U: begin
                        if (is_digit) begin
                            f_next.year       = 8'(pair);
                            f_next.year_given = 1'b1;
                            f_next.phase      = PH_PM;
                        end else begin
                            f_next.phase = PH_TAIL;
                        end
                    end
                    PH_PM: begin
                        if (char_code == CH_PM) begin
                            f_next.pm_seen = 1'b1;
                        end
                        f_next.phase = PH_TAIL;
                    end
                    default: begin
                        f_next = f_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_reg    <= '0;
            tens_reg <= '0;
        end else begin
            f_reg    <= f_next;
            tens_reg <= tens_next;
        end
    end

    assign fields = f_reg;

endmodule

// ===== rtl/dtes_calc.sv =====
// Time calculation: turns the parsed date fields into seconds since 1970 and an error flag.
module dtes_calc (
    input  dtes_pkg::date_fields_t fields,
    input  logic [7:0]             default_year,
    output logic [31:0]            epoch_seconds,
    output logic                   bad_date
);
    import dtes_pkg::*;

    logic [6:0]        hour_adj;
    logic [5:0]        day_adj;
    logic [7:0]        yr;
    logic              leap;
    logic [DAYS_W-1:0] days;
    logic [31:0]       sec;

    // Roll hour 24 into the next day, then apply the afternoon offset
    always_comb begin
        hour_adj = 7'(fields.hour);
        day_adj  = fields.day;
        if (fields.hour == 6'd24) begin
            hour_adj = 7'd0;
            day_adj  = fields.day + 6'd1;
        end
        if (fields.pm_seen) begin
            hour_adj = hour_adj + 7'd12;
        end
    end

    assign bad_date = fields.error_seen || (fields.phase < PH_YR_T) || (hour_adj > 7'd23);

    // Gregorian leap rule over 1900..2155: 1900 and 2100 are not leap years
    assign yr   = fields.year_given ? fields.year : default_year;
    assign leap = (yr[1:0] == 2'b00) && (yr != 8'd0) && (yr != 8'd200);

    // Day count since the epoch
    assign days = YEAR_DAYS[yr]
                + DAYS_W'(leap && (fields.month >= 4'd3))
                + DAYS_W'(days_before_month(fields.month))
                + DAYS_W'(day_adj) - DAYS_W'(1);

    assign sec = 32'(32'(days) * SECS_PER_DAY)
               + 32'(32'(hour_adj) * SECS_PER_HOUR)
               + 32'(32'(fields.minute) * SECS_PER_MIN);

    assign epoch_seconds = bad_date ? 32'd0 : sec;

endmodule
